// ----- rtl/caf_pkg.sv -----
// shared types, constants and helpers of the cursor address formatter
// no dependencies; imported by every module of the block

package caf_pkg;

   localparam int VALUE_WIDTH = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam int BUF_DEPTH  = 4;
   localparam int BCNT_WIDTH = $clog2(BUF_DEPTH + 1);

   // reciprocal of ten, exact quotient for any 32-bit dividend
   localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   localparam logic [9:0] COORD_XOR_MASK = 10'o140;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_UC_B  = 8'h42;
   localparam logic [7:0] CHAR_UC_D  = 8'h44;
   localparam logic [7:0] CHAR_UC_O  = 8'h4F;
   localparam logic [7:0] CHAR_UC_P  = 8'h50;
   localparam logic [7:0] CHAR_UC_S  = 8'h53;
   localparam logic [7:0] CHAR_LC_D  = 8'h64;
   localparam logic [7:0] CHAR_LC_I  = 8'h69;
   localparam logic [7:0] CHAR_LC_N  = 8'h6E;
   localparam logic [7:0] CHAR_LC_R  = 8'h72;

   typedef enum logic [1:0] {
      JOB_LIT  = 2'd0,
      JOB_TERM = 2'd1,
      JOB_OOPS = 2'd2,
      JOB_DEC  = 2'd3
   } job_kind_type;

   typedef enum logic [1:0] {
      FMT_VAR  = 2'd0,
      FMT_PAD2 = 2'd1,
      FMT_PAD3 = 2'd2
   } dec_fmt_type;

   typedef struct packed {
      job_kind_type           kind;
      dec_fmt_type            fmt;
      logic [7:0]             ch;
      logic [VALUE_WIDTH-1:0] value;
   } job_type;

   // quotient by ten through reciprocal multiply
   function automatic logic [31:0] div10(input logic [31:0] a);
      logic [63:0] prod;
      prod = 64'(a) * 64'(RECIP10);
      return 32'(prod >> RECIP_SHIFT);
   endfunction

   // remainder by ten given the quotient
   function automatic logic [3:0] rem10(input logic [31:0] a, input logic [31:0] q);
      return 4'(a - (q << 3) - (q << 1));
   endfunction

endpackage

// ----- rtl/cursor_address_formatter_unit.sv -----
// cursor address formatter: termcap-style cursor addressing, word by word
// top level; ties caf_front, caf_queue and caf_back, depends on caf_pkg
//
// input channel: one template word per push (req_template_char) with the
//   destination column and line; column and line are only taken on the
//   first word of a conversion. a zero template word closes the conversion.
// result channel: a queue of output words (rsp_out_char); rsp_done_res marks
//   the terminator word (char 0) that closes each conversion.
// the front end parses a word per cycle while req_full is low and updates the
//   coordinate state; %B raises req_full while it does its divide by ten.
// a four-entry job queue feeds the back end, which loads each job from the
//   queue in its idle state and then emits its words; OOPS goes out at one
//   word per cycle while the receiver pops. decimal jobs first run the digit
//   converter, one digit a cycle, and then a format step.
// a stalled receiver fills the output register, then the queue, and then
//   req_full rises; nothing is dropped.
// synchronous reset empties the queue and output register and returns the
//   parser to literal mode awaiting the first word of a conversion

module cursor_address_formatter_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_template_char,
   input  logic [9:0] req_column,
   input  logic [9:0] req_line,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_done_res
);
   import caf_pkg::*;

   // jobs between front and back
   job_type front_job;
   job_type back_job;
   logic    job_push;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   caf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_template_char (req_template_char),
      .req_column        (req_column),
      .req_line          (req_line),
      .req_full          (req_full),
      .q_full            (q_full),
      .job_push          (job_push),
      .job               (front_job)
   );

   caf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_job  (back_job)
   );

   // back end owns the output register
   caf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_job        (back_job),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_done_res (rsp_done_res)
   );

endmodule

// ----- rtl/caf_front.sv -----
// front end: takes template words, runs the parser and coordinate state,
// hands print jobs to the queue; depends on caf_pkg

module caf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic [7:0]                        req_template_char,
   input  logic [9:0]                        req_column,
   input  logic [9:0]                        req_line,
   output logic                              req_full,
   input  logic                              q_full,
   output logic                              job_push,
   output caf_pkg::job_type                  job
);
   import caf_pkg::*;

   typedef enum logic [4:0] {
      MODE_NORMAL = 5'b00001,
      MODE_PCT    = 5'b00010,
      MODE_PLUS   = 5'b00100,
      MODE_GT_X   = 5'b01000,
      MODE_GT_Y   = 5'b10000
   } mode_type;

   mode_type               mode_ff, mode_in, eff_mode;
   logic [VALUE_WIDTH-1:0] val_ff, val_in, eff_val;
   logic                   swap_ff, swap_in, eff_swap;
   logic [9:0]             col_ff, col_in, eff_col;
   logic [9:0]             line_ff, line_in, eff_line;
   logic                   conv_ff, conv_in;
   logic                   cond_ff, cond_in, eff_cond;
   logic                   bpend_ff, bpend_in;
   logic [VALUE_WIDTH-1:0] bmag_ff, bmag_in;
   logic                   bneg_ff, bneg_in;

   logic                   accept;
   logic                   job_valid;
   logic [VALUE_WIDTH-1:0] coord;
   logic [VALUE_WIDTH-1:0] eff_mag;
   logic                   eff_neg;
   logic [VALUE_WIDTH-1:0] dmod2;
   logic [31:0]            bq;
   logic [3:0]             br;
   logic [VALUE_WIDTH-1:0] bres;

   assign req_full = q_full || bpend_ff;
   assign accept   = req_push && !req_full;
   assign job_push = accept && job_valid;

   // the first word of a conversion sees the column and line on the request ports
   always_comb begin
      eff_mode = conv_ff ? mode_ff : MODE_NORMAL;
      eff_val  = conv_ff ? val_ff : VALUE_WIDTH'(req_line);
      eff_swap = conv_ff ? swap_ff : 1'b0;
      eff_col  = conv_ff ? col_ff : req_column;
      eff_line = conv_ff ? line_ff : req_line;
      eff_cond = conv_ff ? cond_ff : 1'b0;
   end

   assign coord   = eff_swap ? VALUE_WIDTH'(eff_line) : VALUE_WIDTH'(eff_col);
   assign eff_neg = eff_val[VALUE_WIDTH-1];
   assign eff_mag = eff_neg ? (~eff_val + 1'b1) : eff_val;
   assign dmod2   = VALUE_WIDTH'({eff_mag[3:0], 1'b0});

   // bcd step on the held magnitude
   assign bq   = div10(32'(bmag_ff));
   assign br   = rem10(32'(bmag_ff), bq);
   assign bres = VALUE_WIDTH'({bq, br});

   always_comb begin
      mode_in   = mode_ff;
      val_in    = val_ff;
      swap_in   = swap_ff;
      col_in    = col_ff;
      line_in   = line_ff;
      conv_in   = conv_ff;
      cond_in   = cond_ff;
      bpend_in  = bpend_ff;
      bmag_in   = bmag_ff;
      bneg_in   = bneg_ff;
      job_valid = 1'b0;
      job.kind  = JOB_LIT;
      job.fmt   = FMT_VAR;
      job.ch    = req_template_char;
      job.value = eff_val;

      if (bpend_ff) begin
         val_in   = bneg_ff ? (~bres + 1'b1) : bres;
         bpend_in = 1'b0;
      end else if (accept) begin
         mode_in = eff_mode;
         val_in  = eff_val;
         swap_in = eff_swap;
         col_in  = eff_col;
         line_in = eff_line;
         cond_in = eff_cond;
         conv_in = 1'b1;

         if (req_template_char == CHAR_NUL) begin
            job_valid = 1'b1;
            job.kind  = JOB_TERM;
            mode_in   = MODE_NORMAL;
            cond_in   = 1'b0;
            conv_in   = 1'b0;
         end else begin
            case (eff_mode)
               MODE_PCT: begin
                  mode_in = MODE_NORMAL;
                  case (req_template_char)
                     CHAR_PCT: begin
                        job_valid = 1'b1;
                        job.ch    = CHAR_PCT;
                     end
                     CHAR_LC_D: begin
                        job_valid = 1'b1;
                        job.kind  = JOB_DEC;
                        job.fmt   = FMT_VAR;
                        val_in    = coord;
                     end
                     CHAR_TWO: begin
                        job_valid = 1'b1;
                        job.kind  = JOB_DEC;
                        job.fmt   = FMT_PAD2;
                        val_in    = coord;
                     end
                     CHAR_THREE: begin
                        job_valid = 1'b1;
                        job.kind  = JOB_DEC;
                        job.fmt   = FMT_PAD3;
                        val_in    = coord;
                     end
                     CHAR_DOT: begin
                        job_valid = 1'b1;
                        job.ch    = eff_val[7:0];
                        val_in    = coord;
                     end
                     CHAR_PLUS: begin
                        mode_in = MODE_PLUS;
                     end
                     CHAR_GT: begin
                        mode_in = MODE_GT_X;
                     end
                     CHAR_LC_R: begin
                        val_in  = coord;
                        swap_in = !eff_swap;
                     end
                     CHAR_LC_I: begin
                        val_in = eff_val + 1'b1;
                     end
                     CHAR_LC_N: begin
                        col_in  = eff_col ^ COORD_XOR_MASK;
                        line_in = eff_line ^ COORD_XOR_MASK;
                     end
                     CHAR_UC_B: begin
                        bpend_in = 1'b1;
                        bmag_in  = eff_mag;
                        bneg_in  = eff_neg;
                     end
                     CHAR_UC_D: begin
                        // v - 2*(v rem 16), remainder truncated toward zero
                        val_in = eff_neg ? (eff_val + dmod2) : (eff_val - dmod2);
                     end
                     default: begin
                        job_valid = 1'b1;
                        job.kind  = JOB_OOPS;
                     end
                  endcase
               end
               MODE_PLUS: begin
                  job_valid = 1'b1;
                  job.ch    = eff_val[7:0] + req_template_char;
                  val_in    = coord;
                  mode_in   = MODE_NORMAL;
               end
               MODE_GT_X: begin
                  cond_in = $signed(eff_val) > $signed(VALUE_WIDTH'(req_template_char));
                  mode_in = MODE_GT_Y;
               end
               MODE_GT_Y: begin
                  if (eff_cond) begin
                     val_in = eff_val + VALUE_WIDTH'(req_template_char);
                  end
                  cond_in = 1'b0;
                  mode_in = MODE_NORMAL;
               end
               default: begin
                  if (req_template_char == CHAR_PCT) begin
                     mode_in = MODE_PCT;
                  end else begin
                     job_valid = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         val_ff   <= '0;
         swap_ff  <= 1'b0;
         col_ff   <= '0;
         line_ff  <= '0;
         conv_ff  <= 1'b0;
         cond_ff  <= 1'b0;
         bpend_ff <= 1'b0;
         bneg_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         val_ff   <= val_in;
         swap_ff  <= swap_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
         conv_ff  <= conv_in;
         cond_ff  <= cond_in;
         bpend_ff <= bpend_in;
         bneg_ff  <= bneg_in;
      end
   end

   always_ff @(posedge clock) begin
      bmag_ff <= bmag_in;
   end

endmodule

// ----- rtl/caf_queue.sv -----
// short job queue between the front and back ends
// depends on caf_pkg for the job type and depth

module caf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  caf_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output caf_pkg::job_type pop_job
);
   import caf_pkg::*;

   job_type               slots_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/caf_back.sv -----
// back end: expands print jobs into output words, one per cycle while emitting
// and the output register is free, with a serial decimal converter; depends on caf_pkg

module caf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  caf_pkg::job_type q_job,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_done_res
);
   import caf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_FMT  = 4'b0100,
      ST_EMIT = 4'b1000
   } back_state_type;

   back_state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]        cur_ff, cur_in;
   logic                          neg_ff, neg_in;
   dec_fmt_type                   fmt_ff, fmt_in;
   logic [1:0]                    nd_ff, nd_in;
   logic [2:0][3:0]               win_ff, win_in;
   logic [BUF_DEPTH-1:0][7:0]     obuf_ff, obuf_in;
   logic [BCNT_WIDTH-1:0]         cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic                          out_valid_ff, out_valid_in;
   logic [7:0]                    out_char_ff, out_char_in;
   logic                          out_done_ff, out_done_in;

   logic                          out_ready;
   logic                          emit;
   logic [31:0]                   cq;
   logic [3:0]                    cd;
   logic [BUF_DEPTH-1:0][7:0]     fmt_chars;
   logic [BCNT_WIDTH-1:0]         fmt_len;
   logic [2:0]                    used, minw, pad, pos, k;

   assign out_ready    = !out_valid_ff || rsp_pop;
   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_done_res = out_done_ff;

   // one decimal digit per step, least significant first
   assign cq = div10(32'(cur_ff));
   assign cd = rem10(32'(cur_ff), cq);

   // leading characters of the padded decimal text
   always_comb begin
      used = 3'(neg_ff) + 3'(nd_ff);
      case (fmt_ff)
         FMT_VAR:  minw = 3'd0;
         FMT_PAD2: minw = 3'd2;
         FMT_PAD3: minw = 3'd3;
         default:  minw = 3'd0;
      endcase
      pad     = (minw > used) ? (minw - used) : 3'd0;
      fmt_len = (fmt_ff == FMT_VAR) ? BCNT_WIDTH'(used) : BCNT_WIDTH'(minw);
      pos     = '0;
      k       = '0;
      for (int i = 0; i < BUF_DEPTH; i++) begin
         pos = 3'(i) - 3'(neg_ff);
         k   = pos - pad;
         if (neg_ff && (i == 0)) begin
            fmt_chars[i] = CHAR_MINUS;
         end else if (pos < pad) begin
            fmt_chars[i] = CHAR_ZERO;
         end else if (k < 3'd3) begin
            fmt_chars[i] = CHAR_ZERO + 8'(win_ff[k[1:0]]);
         end else begin
            fmt_chars[i] = CHAR_ZERO;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      neg_in   = neg_ff;
      fmt_in   = fmt_ff;
      nd_in    = nd_ff;
      win_in   = win_ff;
      obuf_in  = obuf_ff;
      cnt_in   = cnt_ff;
      done_in  = done_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               done_in = 1'b0;
               cnt_in  = BCNT_WIDTH'(1);
               case (q_job.kind)
                  JOB_LIT: begin
                     obuf_in[0] = q_job.ch;
                     state_in   = ST_EMIT;
                  end
                  JOB_TERM: begin
                     obuf_in[0] = CHAR_NUL;
                     done_in    = 1'b1;
                     state_in   = ST_EMIT;
                  end
                  JOB_OOPS: begin
                     obuf_in[0] = CHAR_UC_O;
                     obuf_in[1] = CHAR_UC_O;
                     obuf_in[2] = CHAR_UC_P;
                     obuf_in[3] = CHAR_UC_S;
                     cnt_in     = BCNT_WIDTH'(BUF_DEPTH);
                     state_in   = ST_EMIT;
                  end
                  JOB_DEC: begin
                     neg_in   = q_job.value[VALUE_WIDTH-1];
                     cur_in   = q_job.value[VALUE_WIDTH-1] ? (~q_job.value + 1'b1)
                                                           : q_job.value;
                     fmt_in   = q_job.fmt;
                     nd_in    = '0;
                     win_in   = '0;
                     state_in = ST_CONV;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            // window keeps the three most significant digits seen so far
            win_in[0] = cd;
            win_in[1] = win_ff[0];
            win_in[2] = win_ff[1];
            nd_in     = (nd_ff == 2'd3) ? 2'd3 : nd_ff + 1'b1;
            cur_in    = VALUE_WIDTH'(cq);
            if (cq == '0) begin
               state_in = ST_FMT;
            end
         end
         ST_FMT: begin
            obuf_in  = fmt_chars;
            cnt_in   = fmt_len;
            done_in  = 1'b0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_ready) begin
               emit    = 1'b1;
               obuf_in = {8'h00, obuf_ff[BUF_DEPTH-1:1]};
               cnt_in  = cnt_ff - 1'b1;
               if (cnt_ff == BCNT_WIDTH'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_done_in  = out_done_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = obuf_ff[0];
         out_done_in  = done_ff;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      neg_ff      <= neg_in;
      fmt_ff      <= fmt_in;
      nd_ff       <= nd_in;
      win_ff      <= win_in;
      obuf_ff     <= obuf_in;
      done_ff     <= done_in;
      out_char_ff <= out_char_in;
      out_done_ff <= out_done_in;
   end

endmodule
